// File: hdl/scft_pkg.sv
// Shared types and constants for the sorted CAN identifier filter table.
`default_nettype none
package scft_pkg;

    // Field widths of the request and response transfers
    localparam int IDENT_W = 29;
    localparam int INDEX_W = 9;
    localparam int WORD_W  = 32;
    localparam int ADDR_W  = 12;
    localparam int HALF_W  = 16;

    // Command codes
    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_READ   = 1'b1
    } cmd_t;

    // Status codes
    typedef enum logic {
        STATUS_DONE = 1'b0,
        STATUS_FULL = 1'b1
    } status_t;

    // Entry formats
    localparam logic [WORD_W-1:0] STD_ID_MASK = 32'h0000F7FF;
    localparam logic [HALF_W-1:0] STD_PAD     = 16'hFFFF;
    localparam int                STD_CTRL_BIT = 13;
    localparam int                EXT_CTRL_BIT = 29;

endpackage
`default_nettype wire

// File: hdl/scft_req_if.sv
// Request channel: command, identifier and read index.
`default_nettype none
interface scft_req_if;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic                         controller;
    logic                         is_extended;
    logic [scft_pkg::IDENT_W-1:0] ident;
    logic [scft_pkg::INDEX_W-1:0] word_index;

    modport source (
        output valid, command, controller, is_extended, ident, word_index,
        input  ready
    );
    modport sink (
        input  valid, command, controller, is_extended, ident, word_index,
        output ready
    );
endinterface
`default_nettype wire

// File: hdl/scft_rsp_if.sv
// Response channel: status, read word and region end addresses.
`default_nettype none
interface scft_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        status;
    logic [scft_pkg::WORD_W-1:0] word_data;
    logic [scft_pkg::ADDR_W-1:0] std_end_addr;
    logic [scft_pkg::ADDR_W-1:0] ext_end_addr;

    modport source (
        output valid, status, word_data, std_end_addr, ext_end_addr,
        input  ready
    );
    modport sink (
        input  valid, status, word_data, std_end_addr, ext_end_addr,
        output ready
    );
endinterface
`default_nettype wire

// File: hdl/sorted_can_id_filter_table_insert_core.sv
// One request at a time through a single-port table memory and one shared
// compare/merge datapath; a new request is taken once the previous result is queued.
// Reset: asynchronous active low; clears entry counts and control, table left undefined.
`default_nettype none
module sorted_can_id_filter_table_insert_core #(
    parameter int TABLE_WORDS = 512
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    scft_req_if.sink    req,
    scft_rsp_if.source  rsp
);

    localparam int AW  = $clog2(TABLE_WORDS);
    localparam int SCW = AW + 2;
    localparam int ECW = AW + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_XMOVE,
        ST_STD,
        ST_EXT,
        ST_DONE
    } state_t;

    state_t                        state_reg;
    logic [AW-1:0]                 ptr_reg;
    logic [AW-1:0]                 lo_reg;
    logic                          pend_reg;
    logic                          ins_reg;
    logic [scft_pkg::HALF_W-1:0]   carry_reg;
    logic [scft_pkg::WORD_W-1:0]   id_reg;
    logic [SCW-1:0]                std_cnt_reg;
    logic [ECW-1:0]                ext_cnt_reg;
    logic                          status_reg;
    logic [scft_pkg::WORD_W-1:0]   data_reg;
    logic                          inrange_reg;
    logic                          rsp_valid_reg;
    logic                          rsp_status_reg;
    logic [scft_pkg::WORD_W-1:0]   rsp_data_reg;
    logic [scft_pkg::ADDR_W-1:0]   rsp_std_end_reg;
    logic [scft_pkg::ADDR_W-1:0]   rsp_ext_end_reg;

    // Table memory
    logic [scft_pkg::WORD_W-1:0]   mem [TABLE_WORDS];
    logic [scft_pkg::WORD_W-1:0]   rd_data_reg;
    logic                          mem_re;
    logic                          mem_we;
    logic [AW-1:0]                 mem_ra;
    logic [AW-1:0]                 mem_wa;
    logic [scft_pkg::WORD_W-1:0]   mem_wd;

    // Region sizes
    logic [SCW-1:0]                std_cnt_inc;
    logic [AW:0]                   std_words;
    logic [AW+1:0]                 used_words;
    logic                          table_full;
    logic [AW-1:0]                 ext_top;
    logic [AW-1:0]                 std_last;

    // Entry formatting
    logic [scft_pkg::WORD_W-1:0]   std_id;
    logic [scft_pkg::WORD_W-1:0]   ext_id;
    logic [31:0]                   index_wide;

    // Standard word merge
    logic [SCW-1:0]                slot_hi;
    logic [SCW-1:0]                slot_lo;
    logic [scft_pkg::HALF_W-1:0]   old_hi;
    logic [scft_pkg::HALF_W-1:0]   old_lo;
    logic [scft_pkg::HALF_W-1:0]   id16;
    logic [scft_pkg::HALF_W-1:0]   new_hi;
    logic [scft_pkg::HALF_W-1:0]   new_lo;
    logic [scft_pkg::HALF_W-1:0]   carry1;
    logic [scft_pkg::HALF_W-1:0]   carry2;
    logic                          ins1;
    logic                          ins2;
    logic                          ext_gt;

    assign req.ready = (state_reg == ST_IDLE);

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.word_data    = rsp_data_reg;
    assign rsp.std_end_addr = rsp_std_end_reg;
    assign rsp.ext_end_addr = rsp_ext_end_reg;

    // Derive region sizes from the entry counts
    always_comb
    begin
        std_cnt_inc = std_cnt_reg + SCW'(1);
        std_words   = std_cnt_inc[SCW-1:1];
        used_words  = {1'b0, std_words} + (AW+2)'(ext_cnt_reg);
        table_full  = (used_words >= (AW+2)'(TABLE_WORDS));
        ext_top     = used_words[AW-1:0];
        std_last    = std_cnt_reg[AW:1];
    end

    // Format the new entry from the request fields
    always_comb
    begin
        std_id     = (32'(req.ident)
                      | (32'(req.controller) << scft_pkg::STD_CTRL_BIT))
                     & scft_pkg::STD_ID_MASK;
        ext_id     = 32'(req.ident) | (32'(req.controller) << scft_pkg::EXT_CTRL_BIT);
        index_wide = 32'(req.word_index);
    end

    // Merge one standard word: shift halves along and drop the new entry in place
    always_comb
    begin
        slot_hi = SCW'({ptr_reg, 1'b0});
        slot_lo = SCW'({ptr_reg, 1'b1});
        old_hi  = rd_data_reg[31:16];
        old_lo  = rd_data_reg[15:0];
        id16    = id_reg[15:0];

        if (ins_reg)
        begin
            new_hi = carry_reg;
            carry1 = old_hi;
            ins1   = 1'b1;
        end
        else if ((slot_hi >= std_cnt_reg) || (old_hi > id16))
        begin
            new_hi = id16;
            carry1 = old_hi;
            ins1   = 1'b1;
        end
        else
        begin
            new_hi = old_hi;
            carry1 = carry_reg;
            ins1   = 1'b0;
        end

        if (slot_lo > std_cnt_reg)
        begin
            new_lo = scft_pkg::STD_PAD;
            carry2 = carry1;
            ins2   = ins1;
        end
        else if (ins1)
        begin
            new_lo = carry1;
            carry2 = old_lo;
            ins2   = 1'b1;
        end
        else if ((slot_lo >= std_cnt_reg) || (old_lo > id16))
        begin
            new_lo = id16;
            carry2 = old_lo;
            ins2   = 1'b1;
        end
        else
        begin
            new_lo = old_lo;
            carry2 = carry1;
            ins2   = 1'b0;
        end

        ext_gt = (rd_data_reg > id_reg);
    end

    // Drive the memory port from the sequencer
    always_comb
    begin
        mem_re = 1'b0;
        mem_we = 1'b0;
        mem_ra = ptr_reg;
        mem_wa = ptr_reg;
        mem_wd = rd_data_reg;
        unique case (state_reg)
            ST_READ:
            begin
                mem_re = !pend_reg;
            end
            ST_XMOVE:
            begin
                mem_re = !pend_reg;
                mem_we = pend_reg;
                mem_wa = ptr_reg + AW'(1);
            end
            ST_STD:
            begin
                mem_re = !pend_reg;
                mem_we = pend_reg;
                mem_wd = {new_hi, new_lo};
            end
            ST_EXT:
            begin
                if (!pend_reg)
                begin
                    if (ptr_reg == lo_reg)
                    begin
                        mem_we = 1'b1;
                        mem_wd = id_reg;
                    end
                    else
                    begin
                        mem_re = 1'b1;
                        mem_ra = ptr_reg - AW'(1);
                    end
                end
                else
                begin
                    mem_we = 1'b1;
                    mem_wd = ext_gt ? rd_data_reg : id_reg;
                end
            end
            ST_IDLE, ST_DONE:
            begin
                mem_re = 1'b0;
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    // Hold the table
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    // Sequence one request and register the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            ins_reg       <= 1'b0;
            std_cnt_reg   <= '0;
            ext_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            // Drop the result once transferred, unless a new one replaces it
            if (rsp_valid_reg && rsp.ready && (state_reg != ST_DONE))
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    pend_reg   <= 1'b0;
                    ins_reg    <= 1'b0;
                    status_reg <= (table_full && (req.command == scft_pkg::CMD_INSERT))
                                  ? scft_pkg::STATUS_FULL : scft_pkg::STATUS_DONE;
                    data_reg   <= '0;
                    if (req.valid)
                    begin
                        if (req.command == scft_pkg::CMD_READ)
                        begin
                            inrange_reg <= (index_wide < 32'(TABLE_WORDS));
                            ptr_reg     <= index_wide[AW-1:0];
                            state_reg   <= ST_READ;
                        end
                        else if (table_full)
                        begin
                            state_reg  <= ST_DONE;
                        end
                        else if (req.is_extended)
                        begin
                            id_reg    <= ext_id;
                            ptr_reg   <= ext_top;
                            lo_reg    <= std_words[AW-1:0];
                            state_reg <= ST_EXT;
                        end
                        else
                        begin
                            id_reg <= std_id;
                            lo_reg <= std_words[AW-1:0];
                            if (!std_cnt_reg[0] && (ext_cnt_reg != '0))
                            begin
                                ptr_reg   <= ext_top - AW'(1);
                                state_reg <= ST_XMOVE;
                            end
                            else
                            begin
                                ptr_reg   <= '0;
                                state_reg <= ST_STD;
                            end
                        end
                    end
                end
                ST_READ:
                begin
                    pend_reg <= 1'b1;
                    if (pend_reg)
                    begin
                        data_reg  <= inrange_reg ? rd_data_reg : '0;
                        state_reg <= ST_DONE;
                    end
                end
                ST_XMOVE:
                begin
                    // Move the extended region one word higher, last word first
                    pend_reg <= !pend_reg;
                    if (pend_reg)
                    begin
                        if (ptr_reg == lo_reg)
                        begin
                            ptr_reg   <= '0;
                            state_reg <= ST_STD;
                        end
                        else
                        begin
                            ptr_reg <= ptr_reg - AW'(1);
                        end
                    end
                end
                ST_STD:
                begin
                    pend_reg <= !pend_reg;
                    if (pend_reg)
                    begin
                        ins_reg   <= ins2;
                        carry_reg <= carry2;
                        if (ptr_reg == std_last)
                        begin
                            std_cnt_reg <= std_cnt_inc;
                            state_reg   <= ST_DONE;
                        end
                        else
                        begin
                            ptr_reg <= ptr_reg + AW'(1);
                        end
                    end
                end
                ST_EXT:
                begin
                    // Walk down from the end, shifting larger entries along
                    if (!pend_reg)
                    begin
                        if (ptr_reg == lo_reg)
                        begin
                            ext_cnt_reg <= ext_cnt_reg + ECW'(1);
                            state_reg   <= ST_DONE;
                        end
                        else
                        begin
                            pend_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                        if (ext_gt)
                        begin
                            ptr_reg <= ptr_reg - AW'(1);
                        end
                        else
                        begin
                            ext_cnt_reg <= ext_cnt_reg + ECW'(1);
                            state_reg   <= ST_DONE;
                        end
                    end
                end
                ST_DONE:
                begin
                    if (!rsp_valid_reg || rsp.ready)
                    begin
                        rsp_valid_reg   <= 1'b1;
                        rsp_status_reg  <= status_reg;
                        rsp_data_reg    <= data_reg;
                        rsp_std_end_reg <= scft_pkg::ADDR_W'({std_words, 2'b00});
                        rsp_ext_end_reg <= scft_pkg::ADDR_W'({used_words, 2'b00});
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // After a transfer in, ready is low in the next cycle
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request taken while busy");

    // The table is never written while idle, reading or reporting
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_DONE || state_reg == ST_READ) |-> !mem_we)
        else $error("table written outside an insert");

    // The regions never outgrow the table
    a_fits: assert property (@(posedge clk) disable iff (!rst_n)
        used_words <= (AW+2)'(TABLE_WORDS))
        else $error("table overflow");
`endif

endmodule
`default_nettype wire
